>>> design/scfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scfr_pkg;

  // Request kinds carried in the func field.
  localparam logic [1:0] FUNC_SPI   = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_REL   = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // Command opcodes (high byte of a command word).
  localparam logic [7:0] OP_SEND  = 8'h03;
  localparam logic [7:0] OP_RECV  = 8'h04;
  localparam logic [7:0] OP_PARAM = 8'h05;
  localparam logic [7:0] OP_SPEED = 8'h07;

  // The one word that gets through while the framer waits for the host.
  localparam logic [15:0] RESET_WORD = 16'h0902;

  // Framer phases.
  localparam logic [3:0] PH_NEW        = 4'd0;
  localparam logic [3:0] PH_ONE_OF_ONE = 4'd1;
  localparam logic [3:0] PH_ONE_OF_TWO = 4'd2;
  localparam logic [3:0] PH_TWO_OF_TWO = 4'd3;
  localparam logic [3:0] PH_SPEED      = 4'd4;
  localparam logic [3:0] PH_SEND       = 4'd5;
  localparam logic [3:0] PH_RECV       = 4'd6;

  // What the transmit word of a result carries.
  localparam logic [1:0] TXK_NONE  = 2'd0;
  localparam logic [1:0] TXK_COUNT = 2'd1;
  localparam logic [1:0] TXK_BUF   = 2'd2;
  localparam logic [1:0] TXK_CRC   = 2'd3;

  localparam int unsigned NUM_MASK_REGS = 4;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] word;
    logic [5:0]  index;
    logic        prepared;
    logic [7:0]  crc;
  } in_t;

  typedef struct packed {
    logic               cmd_ready;
    logic [15:0]        cmd_word;
    logic [15:0]        param_a;
    logic [15:0]        param_b;
    logic signed [15:0] speed;
    logic [7:0]         recv_crc;
    logic               tx_valid;
    logic [15:0]        tx_word;
    logic [15:0]        read_data;
    logic               busy_res;
  } out_t;

  // Per-request snapshot handed from the framer to the result stage; the
  // buffer word itself arrives from the RAM in the same cycle as the snapshot.
  typedef struct packed {
    logic               rd_host;
    logic               rd_ok;
    logic [1:0]         tx_kind;
    logic               tx_buf_ok;
    logic [7:0]         tx_crc;
    logic               busy;
    logic [15:0]        cmd;
    logic [15:0]        a;
    logic [15:0]        b;
    logic signed [15:0] speed;
    logic [7:0]         rcrc;
  } item_t;

endpackage

`default_nettype wire

>>> design/spi_command_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none

// Slave-side framer for 16-bit SPI command words. Each request is either a
// received SPI word, a host write or read of the word buffer, or a host
// release, and each request produces exactly one result carrying the latched
// command, parameters, speed and receive CRC, the busy flag, an optional
// transmit word and the host read data. The block takes one request per
// clock while the snapshot stage has room: the framer state and the buffer
// write are updated at the edge that accepts a request, the buffer read
// issued at that same edge is registered in the RAM alongside the snapshot,
// and the result then sits in an output register, loaded from the snapshot
// stage once the output register is free. A new request is taken every
// cycle as long as the output side keeps up. Reads of buffer entries that
// were never written return unspecified data.
module spi_command_frame_receiver #(
  parameter int BUFFER_DEPTH = 64,
  parameter int TX_WORDS     = 48
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [63:0]     cfg_data,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire scfr_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output scfr_pkg::out_t       out_data
);

  import scfr_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic          accept;
  logic          s1_valid;
  item_t         item;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_wdata;
  logic [15:0]   mem_rdata;

  // A request is taken when it is offered and the snapshot stage has room.
  assign accept = in_valid && !in_stall;

  // Framer state, mask registers and the buffer address and write selection.
  scfr_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .TX_WORDS    (TX_WORDS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .req      (in_data),
    .item     (item),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr)
  );

  // The read is enabled only with an accepted request, so the read data
  // stays put while the snapshot stage waits on the output side.
  scfr_ram #(
    .WIDTH(16),
    .DEPTH(BUFFER_DEPTH)
  ) u_buffer (
    .clk  (clk),
    .we   (mem_we && accept),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (accept),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Result assembly and the output register.
  scfr_out #(
    .TX_WORDS(TX_WORDS)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .mem_rdata(mem_rdata),
    .in_stall (in_stall),
    .s1_valid (s1_valid),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  // Every accepted request is held in the snapshot stage on the next cycle.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted request did not reach the snapshot stage");

  // A result without a transmit word carries a zero transmit word.
  a_tx_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.tx_valid) |-> (out_data.tx_word == 16'h0000))
    else $error("transmit word set without transmit valid");

  // The ready and busy indications of a result always agree.
  a_busy_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.cmd_ready == out_data.busy_res))
    else $error("cmd_ready and busy_res disagree");

  // A stalled request implies a full snapshot stage.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stalled with room to spare");
`endif

endmodule

`default_nettype wire

>>> design/scfr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module scfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/scfr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module scfr_ctrl #(
  parameter int BUFFER_DEPTH = 64,
  parameter int TX_WORDS     = 48
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [63:0]                     cfg_data,
  input  wire logic                            accept,
  input  wire scfr_pkg::in_t                   req,
  output scfr_pkg::item_t                      item,
  output logic                                 mem_we,
  output logic [$clog2(BUFFER_DEPTH)-1:0]      mem_waddr,
  output logic [15:0]                          mem_wdata,
  output logic [$clog2(BUFFER_DEPTH)-1:0]      mem_raddr
);

  import scfr_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam logic [8:0] DEPTH_W = 9'(BUFFER_DEPTH);
  localparam logic [6:0] TX_LAST = 7'(TX_WORDS);

  logic [63:0] wide_mask [NUM_MASK_REGS];

  logic [3:0]  phase, phase_next;
  logic        ready_flag, ready_flag_next;
  logic        tx_prepared, tx_prepared_next;
  logic [6:0]  send_pos, send_pos_next;
  logic [7:0]  recv_pos, recv_pos_next;
  logic [7:0]  recv_expected, recv_expected_next;
  logic [7:0]  tx_crc, tx_crc_next;
  logic [15:0] latched_cmd, latched_cmd_next;
  logic [15:0] latched_a, latched_a_next;
  logic [15:0] latched_b, latched_b_next;
  logic [15:0] latched_speed, latched_speed_next;
  logic [7:0]  latched_rcrc, latched_rcrc_next;

  logic [7:0] op, arg;
  logic       mask_hit;
  logic [7:0] waddr8, raddr8;

  assign op  = req.word[15:8];
  assign arg = req.word[7:0];
  assign mask_hit = wide_mask[arg[7:6]][arg[5:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_MASK_REGS; i++) begin
        wide_mask[i] <= '0;
      end
    end else if (cfg_write) begin
      wide_mask[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    phase_next         = phase;
    ready_flag_next    = ready_flag;
    tx_prepared_next   = tx_prepared;
    send_pos_next      = send_pos;
    recv_pos_next      = recv_pos;
    recv_expected_next = recv_expected;
    tx_crc_next        = tx_crc;
    latched_cmd_next   = latched_cmd;
    latched_a_next     = latched_a;
    latched_b_next     = latched_b;
    latched_speed_next = latched_speed;
    latched_rcrc_next  = latched_rcrc;
    mem_we    = 1'b0;
    waddr8    = {2'b00, req.index};
    mem_wdata = req.word;
    raddr8    = (req.func == FUNC_READ) ? {2'b00, req.index} : {1'b0, send_pos};
    item.tx_kind = TXK_NONE;

    unique case (req.func)
      FUNC_WRITE: begin
        mem_we = ({3'b000, req.index} < DEPTH_W);
      end
      FUNC_REL: begin
        ready_flag_next = 1'b1;
        if (req.prepared) begin
          tx_prepared_next = 1'b1;
          tx_crc_next      = req.crc;
        end
      end
      FUNC_READ: begin
      end
      default: begin
        if (ready_flag || req.word == RESET_WORD) begin
          unique case (phase)
            PH_NEW: begin
              latched_cmd_next = req.word;
              if (op == OP_SEND) begin
                item.tx_kind    = TXK_COUNT;
                phase_next      = PH_SEND;
                ready_flag_next = 1'b0;
              end else if (op == OP_RECV) begin
                phase_next         = PH_RECV;
                recv_expected_next = arg;
              end else if (op == OP_PARAM) begin
                phase_next = mask_hit ? PH_ONE_OF_ONE : PH_ONE_OF_TWO;
              end else if (op == OP_SPEED) begin
                phase_next = PH_SPEED;
              end else begin
                ready_flag_next = 1'b0;
              end
            end
            PH_ONE_OF_ONE: begin
              latched_a_next  = req.word;
              phase_next      = PH_NEW;
              ready_flag_next = 1'b0;
            end
            PH_ONE_OF_TWO: begin
              latched_a_next = req.word;
              phase_next     = PH_TWO_OF_TWO;
            end
            PH_TWO_OF_TWO: begin
              latched_b_next  = req.word;
              phase_next      = PH_NEW;
              ready_flag_next = 1'b0;
            end
            PH_SPEED: begin
              latched_speed_next = req.word;
              phase_next         = PH_NEW;
              ready_flag_next    = 1'b0;
            end
            PH_SEND: begin
              if (tx_prepared) begin
                if (send_pos < TX_LAST) begin
                  item.tx_kind  = TXK_BUF;
                  send_pos_next = send_pos + 7'd1;
                end else begin
                  item.tx_kind     = TXK_CRC;
                  send_pos_next    = '0;
                  tx_prepared_next = 1'b0;
                  phase_next       = PH_NEW;
                  ready_flag_next  = 1'b1;
                end
              end
            end
            PH_RECV: begin
              if (recv_pos < recv_expected) begin
                waddr8        = recv_pos;
                mem_we        = ({1'b0, recv_pos} < DEPTH_W);
                recv_pos_next = recv_pos + 8'd1;
              end else begin
                latched_rcrc_next  = req.word[7:0];
                recv_pos_next      = '0;
                recv_expected_next = '0;
                phase_next         = PH_NEW;
                ready_flag_next    = 1'b0;
              end
            end
            default: begin
              phase_next = PH_NEW;
            end
          endcase
        end
      end
    endcase

    item.rd_host   = (req.func == FUNC_READ);
    item.rd_ok     = ({3'b000, req.index} < DEPTH_W);
    item.tx_buf_ok = ({2'b00, send_pos} < DEPTH_W);
    item.tx_crc    = tx_crc;
    item.busy      = !ready_flag_next;
    item.cmd       = latched_cmd_next;
    item.a         = latched_a_next;
    item.b         = latched_b_next;
    item.speed     = $signed(latched_speed_next);
    item.rcrc      = latched_rcrc_next;
  end

  assign mem_waddr = waddr8[AW-1:0];
  assign mem_raddr = raddr8[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_NEW;
      ready_flag    <= 1'b1;
      tx_prepared   <= 1'b0;
      send_pos      <= '0;
      recv_pos      <= '0;
      recv_expected <= '0;
      tx_crc        <= '0;
      latched_cmd   <= '0;
      latched_a     <= '0;
      latched_b     <= '0;
      latched_speed <= '0;
      latched_rcrc  <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      ready_flag    <= ready_flag_next;
      tx_prepared   <= tx_prepared_next;
      send_pos      <= send_pos_next;
      recv_pos      <= recv_pos_next;
      recv_expected <= recv_expected_next;
      tx_crc        <= tx_crc_next;
      latched_cmd   <= latched_cmd_next;
      latched_a     <= latched_a_next;
      latched_b     <= latched_b_next;
      latched_speed <= latched_speed_next;
      latched_rcrc  <= latched_rcrc_next;
    end
  end

endmodule

`default_nettype wire

>>> design/scfr_out.sv
`timescale 1ns / 1ps
`default_nettype none

module scfr_out #(
  parameter int TX_WORDS = 48
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire scfr_pkg::item_t   item,
  input  wire logic [15:0]       mem_rdata,
  output logic                   in_stall,
  output logic                   s1_valid,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output scfr_pkg::out_t         out_data
);

  import scfr_pkg::*;

  item_t s1_item;
  out_t  result;
  logic  s1_move;

  // The snapshot stage moves on whenever the output register is empty or
  // being emptied this cycle.
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
  end

  always_comb begin
    result.cmd_ready = s1_item.busy;
    result.busy_res  = s1_item.busy;
    result.cmd_word  = s1_item.cmd;
    result.param_a   = s1_item.a;
    result.param_b   = s1_item.b;
    result.speed     = s1_item.speed;
    result.recv_crc  = s1_item.rcrc;
    result.read_data = (s1_item.rd_host && s1_item.rd_ok) ? mem_rdata : '0;
    result.tx_valid  = (s1_item.tx_kind != TXK_NONE);
    case (s1_item.tx_kind)
      TXK_COUNT: result.tx_word = 16'(TX_WORDS);
      TXK_BUF:   result.tx_word = s1_item.tx_buf_ok ? mem_rdata : '0;
      TXK_CRC:   result.tx_word = {8'h00, s1_item.tx_crc};
      default:   result.tx_word = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> bench/tb_spi_command_frame_receiver.sv
`timescale 1ns / 1ps

// Self-checking bench for the SPI command framer. Every accepted request is
// run through a cycle-free copy of the framer kept in the frame_checker class,
// and the result it predicts is queued. Each result the block hands out is
// compared field by field with the oldest queued one.
module tb_spi_command_frame_receiver;
  import scfr_pkg::*;

  localparam int BUF_WORDS    = 64;
  localparam int STREAM_WORDS = 48;
  localparam int PHASE_BUDGET = 190;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;

  // When set, neither side idles: back-to-back requests and results.
  bit calm = 1'b0;
  // Requests that did something, i.e. not SPI words dropped by the busy filter.
  int effective_count = 0;

  class frame_checker;
    logic [255:0] param_mask;
    logic [3:0]   phase;
    bit           ready;
    bit           tx_armed;
    logic [6:0]   send_pos;
    logic [7:0]   recv_pos;
    logic [7:0]   recv_expected;
    logic [7:0]   tx_crc;
    logic [7:0]   rcrc;
    logic [15:0]  cmd;
    logic [15:0]  a;
    logic [15:0]  b;
    logic [15:0]  spd;
    logic [15:0]  store [BUF_WORDS];
    out_t         due_results [$];
    int           failures;
    bit           last_applied;

    function new();
      param_mask    = '0;
      phase         = PH_NEW;
      ready         = 1'b1;
      tx_armed      = 1'b0;
      send_pos      = '0;
      recv_pos      = '0;
      recv_expected = '0;
      tx_crc        = '0;
      rcrc          = '0;
      cmd           = '0;
      a             = '0;
      b             = '0;
      spd           = '0;
      failures      = 0;
      last_applied  = 1'b0;
    endfunction

    // Applies one request to the framer copy and returns the result it causes.
    function out_t advance_framer(in_t r);
      out_t       o;
      logic [7:0] op;
      logic [7:0] arg;
      o   = '0;
      op  = r.word[15:8];
      arg = r.word[7:0];
      case (r.func)
        FUNC_WRITE: store[r.index] = r.word;
        FUNC_REL: begin
          ready = 1'b1;
          if (r.prepared) begin
            tx_armed = 1'b1;
            tx_crc   = r.crc;
          end
        end
        FUNC_READ: o.read_data = store[r.index];
        default: begin
          if (ready || r.word == RESET_WORD) begin
            case (phase)
              PH_NEW: begin
                cmd = r.word;
                if (op == OP_SEND) begin
                  o.tx_valid = 1'b1;
                  o.tx_word  = 16'(STREAM_WORDS);
                  phase      = PH_SEND;
                  ready      = 1'b0;
                end else if (op == OP_RECV) begin
                  phase         = PH_RECV;
                  recv_expected = arg;
                end else if (op == OP_PARAM) begin
                  phase = param_mask[arg] ? PH_ONE_OF_ONE : PH_ONE_OF_TWO;
                end else if (op == OP_SPEED) begin
                  phase = PH_SPEED;
                end else begin
                  ready = 1'b0;
                end
              end
              PH_ONE_OF_ONE: begin
                a     = r.word;
                phase = PH_NEW;
                ready = 1'b0;
              end
              PH_ONE_OF_TWO: begin
                a     = r.word;
                phase = PH_TWO_OF_TWO;
              end
              PH_TWO_OF_TWO: begin
                b     = r.word;
                phase = PH_NEW;
                ready = 1'b0;
              end
              PH_SPEED: begin
                spd   = r.word;
                phase = PH_NEW;
                ready = 1'b0;
              end
              PH_SEND: begin
                // Words only clock data out once the host has prepared it.
                if (tx_armed) begin
                  o.tx_valid = 1'b1;
                  if (send_pos < STREAM_WORDS) begin
                    o.tx_word = store[send_pos];
                    send_pos  = send_pos + 7'd1;
                  end else begin
                    o.tx_word = {8'h00, tx_crc};
                    send_pos  = '0;
                    tx_armed  = 1'b0;
                    phase     = PH_NEW;
                    ready     = 1'b1;
                  end
                end
              end
              PH_RECV: begin
                if (recv_pos < recv_expected) begin
                  // Words past the end of the buffer are counted but dropped.
                  if (recv_pos < BUF_WORDS) store[recv_pos] = r.word;
                  recv_pos = recv_pos + 8'd1;
                end else begin
                  rcrc          = r.word[7:0];
                  recv_pos      = '0;
                  recv_expected = '0;
                  phase         = PH_NEW;
                  ready         = 1'b0;
                end
              end
              default: phase = PH_NEW;
            endcase
          end
        end
      endcase
      o.cmd_ready = !ready;
      o.busy_res  = !ready;
      o.cmd_word  = cmd;
      o.param_a   = a;
      o.param_b   = b;
      o.speed     = spd;
      o.recv_crc  = rcrc;
      return o;
    endfunction

    function void note_request(in_t r);
      last_applied = (r.func != FUNC_SPI) || ready || (r.word == RESET_WORD);
      due_results.push_back(advance_framer(r));
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (due_results.size() == 0) begin
        failures++;
        $display("%0t: result with no request outstanding, expected none, actual %h",
                 $time, got);
        return;
      end
      want = due_results.pop_front();
      compare_field("cmd_ready", want.cmd_ready, got.cmd_ready);
      compare_field("cmd_word", want.cmd_word, got.cmd_word);
      compare_field("param_a", want.param_a, got.param_a);
      compare_field("param_b", want.param_b, got.param_b);
      compare_field("speed", want.speed, got.speed);
      compare_field("recv_crc", want.recv_crc, got.recv_crc);
      compare_field("tx_valid", want.tx_valid, got.tx_valid);
      compare_field("tx_word", want.tx_word, got.tx_word);
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("busy_res", want.busy_res, got.busy_res);
    endfunction
  endclass

  frame_checker frames = new();

  spi_command_frame_receiver #(
    .BUFFER_DEPTH(BUF_WORDS),
    .TX_WORDS(STREAM_WORDS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The result side stalls at random except in calm stretches.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 34);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) frames.check_result(out_data);
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic in_t make_req(logic [1:0] f, logic [15:0] w, logic [5:0] idx,
                                   logic prep, logic [7:0] c);
    in_t r;
    r.func     = f;
    r.word     = w;
    r.index    = idx;
    r.prepared = prep;
    r.crc      = c;
    return r;
  endfunction

  // Data words lean toward the extremes now and then.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h7FFF;
      3: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one request and returns at the edge that takes it. Valid is left
  // high so that the next request can follow without a bubble. Each cycle
  // before the offer is idle with the same chance as the result side.
  task automatic send_request(input in_t r);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    frames.note_request(r);
    if (frames.last_applied) effective_count++;
  endtask

  task automatic spi_word(input logic [15:0] w);
    send_request(make_req(FUNC_SPI, w, 6'($urandom), 1'($urandom), 8'($urandom)));
  endtask

  task automatic host_free(input logic prep, input logic [7:0] c);
    send_request(make_req(FUNC_REL, 16'($urandom), 6'($urandom), prep, c));
  endtask

  task automatic host_access(input logic [1:0] f, input logic [5:0] idx,
                             input logic [15:0] w);
    send_request(make_req(f, w, idx, 1'($urandom), 8'($urandom)));
  endtask

  task automatic load_mask(input logic [255:0] m);
    for (int i = 0; i < NUM_MASK_REGS; i++) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= m[64*i +: 64];
    end
    @(negedge clk);
    cfg_write <= 1'b0;
    frames.param_mask = m;
  endtask

  // Stops offering requests and waits for every queued result, then idles
  // on, so nothing is in flight when the mask changes or the run ends.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frames.due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Brings the framer back to a fresh command: releases the host wait,
  // finishes a stream, or pads an open frame with data words.
  task automatic settle_framer();
    while (!(frames.phase == PH_NEW && frames.ready)) begin
      if (!frames.ready)
        host_free((frames.phase == PH_SEND) ? 1'b1 : 1'($urandom), 8'($urandom));
      else if (frames.phase == PH_SEND && !frames.tx_armed)
        host_free(1'b1, 8'($urandom));
      else
        spi_word(pick_word());
    end
  endtask

  task automatic host_traffic();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      case ($urandom_range(0, 4))
        0, 1: host_access(FUNC_WRITE, 6'($urandom), pick_word());
        2, 3: host_access(FUNC_READ, 6'($urandom), 16'($urandom));
        default: host_free(1'($urandom), 8'($urandom));
      endcase
    end
  endtask

  // Supplies data words for an open parameter, speed or receive frame. Now and
  // then the frame is cut short so that a later command lands inside it.
  task automatic feed_framer();
    bit cut;
    cut = ($urandom_range(0, 9) == 0);
    while (frames.ready && frames.phase != PH_NEW && frames.phase != PH_SEND && !cut) begin
      if ($urandom_range(0, 19) == 0) host_traffic();
      spi_word(pick_word());
    end
  endtask

  task automatic stream_transfer();
    spi_word({OP_SEND, 8'($urandom)});
    // The reset word slips past the busy filter into the stream phase.
    if ($urandom_range(0, 3) == 0) spi_word(RESET_WORD);
    if ($urandom_range(0, 2) == 0) begin
      // Released without data: unless still armed, the words are swallowed.
      host_free(1'b0, 8'($urandom));
      repeat ($urandom_range(1, 3)) spi_word(16'($urandom));
    end
    if ($urandom_range(0, 1) == 0) host_traffic();
    host_free(1'b1, 8'($urandom));
    while (frames.phase == PH_SEND) begin
      if (!frames.ready || !frames.tx_armed)
        host_free(1'b1, 8'($urandom));
      else if ($urandom_range(0, 15) == 0)
        host_traffic();
      else
        spi_word(16'($urandom));
    end
  endtask

  task automatic random_phase(input int target);
    int start;
    int pick;
    start = effective_count;
    while (effective_count - start < target) begin
      if ($urandom_range(0, 9) != 0) settle_framer();
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        spi_word({OP_PARAM, 8'($urandom)});
        feed_framer();
      end else if (pick < 40) begin
        // Mostly short receives; a few run well past the buffer end.
        spi_word({OP_RECV, ($urandom_range(0, 11) == 0) ? 8'($urandom_range(64, 255))
                                                         : 8'($urandom_range(0, 12))});
        feed_framer();
      end else if (pick < 52) begin
        spi_word({OP_SPEED, 8'($urandom)});
        feed_framer();
      end else if (pick < 58) begin
        stream_transfer();
      end else if (pick < 70) begin
        spi_word(16'($urandom));
        feed_framer();
      end else if (pick < 82) begin
        // A plain command makes the block busy; the words after it are
        // dropped unless they are the reset word.
        spi_word({8'h80 | 8'($urandom), 8'($urandom)});
        repeat ($urandom_range(1, 4))
          spi_word(($urandom_range(0, 3) == 0) ? RESET_WORD : 16'($urandom));
      end else begin
        host_traffic();
      end
    end
  endtask

  initial begin
    logic [255:0] m;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // First mask: index 0 takes two words, index 255 takes one.
    m = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    m[0]   = 1'b0;
    m[255] = 1'b1;
    load_mask(m);

    // Fill the whole buffer so that no read or stream ever sees an unwritten entry.
    for (int i = 0; i < BUF_WORDS; i++)
      host_access(FUNC_WRITE, 6'(i), (i == BUF_WORDS - 1) ? 16'hFFFF : 16'($urandom));

    // Directed requests.
    host_access(FUNC_READ, 6'd63, 16'h0000);
    host_access(FUNC_READ, 6'd0, 16'hFFFF);
    spi_word(RESET_WORD);            // an ordinary command when idle: busy at once
    spi_word(16'h1234);              // dropped while busy
    host_free(1'b0, 8'h00);
    spi_word({OP_PARAM, 8'h00});     // two data words
    spi_word(16'h0000);
    spi_word(16'hFFFF);
    host_free(1'b0, 8'hFF);
    spi_word({OP_PARAM, 8'hFF});     // one data word
    spi_word(16'hA5A5);
    spi_word(RESET_WORD);            // passes the busy filter
    host_free(1'b0, 8'h00);
    spi_word({OP_SPEED, 8'h00});
    spi_word(16'h8000);
    host_free(1'b0, 8'h00);
    spi_word({OP_SPEED, 8'hFF});
    spi_word(16'h7FFF);
    host_free(1'b1, 8'hFF);          // release with data while busy
    spi_word({OP_RECV, 8'h00});      // no data, the next word is the CRC
    spi_word(16'hFFAB);
    host_free(1'b0, 8'h00);
    spi_word({OP_RECV, 8'h02});
    spi_word(16'hFFFF);
    spi_word(16'h0001);
    spi_word(16'h0000);
    host_free(1'b0, 8'h00);

    random_phase(PHASE_BUDGET);
    drain();
    load_mask('0);
    random_phase(PHASE_BUDGET);
    drain();
    calm = 1'b1;
    load_mask('1);
    random_phase(PHASE_BUDGET);
    drain();
    calm = 1'b0;
    load_mask({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    random_phase(PHASE_BUDGET);
    drain();
    load_mask({4{64'h5555_5555_5555_5555}});
    random_phase(PHASE_BUDGET);
    drain();

    if (frames.failures == 0 && frames.due_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
